[rtl/pfra_pkg.sv]
// shared constants, codes and helpers of the page frame refcount allocator
package pfra_pkg;

    localparam int NUM_FRAMES = 4096;
    localparam int COUNT_BITS = 8;

    localparam int FRAME_W = 12;
    localparam int LIMIT_W = 13;
    localparam int STATUS_W = 3;
    localparam int OUT_CNT_W = 8;
    localparam int INDEX_SPAN = 4096;

    localparam int DEPTH = (NUM_FRAMES < INDEX_SPAN) ? NUM_FRAMES : INDEX_SPAN;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_SHARE = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RESERVED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SATURATED    = 3'd5;

    localparam logic REG_FIRST_ALLOC = 1'b0;
    localparam logic REG_FRAME_LIMIT = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;

    function automatic logic [OUT_CNT_W-1:0] cnt_to_out(input count_t c);
        logic [15:0] w;
        w = 16'(c);
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

[rtl/page_frame_refcount_allocator_top.sv]
// page frame allocator with per-frame reference counts, top level
//
//  channel   dir   handshake                 payload
//  s_        in    s_tvalid / s_tready       s_tdata: command, frame_index
//  m_        out   m_tvalid / m_tready       m_tdata: status, result_frame, ref_count
//  cfg_      in    cfg_valid / cfg_ready     cfg_addr: register, cfg_data: value
//
//  free, share, query: through S_EVAL to S_OUT; a frame beyond the limit goes straight to S_OUT
//  allocate: scans frames down from the limit to the first allocatable frame through
//  the single read port of the count memory; no free frame without a scan if range empty
//  after reset a clearing pass zeroes every entry of the count memory with s_tready low;
//  config writes are taken throughout
//  one word at a time; a result stalled on m_ holds back the following result and further input
module page_frame_refcount_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] command, [13:2] frame_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [14:3] result_frame, [22:15] ref_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [12:0] cfg_data
);

    localparam int AW = pfra_pkg::ADDR_W;
    localparam int FW = pfra_pkg::FRAME_W;
    localparam int LW = pfra_pkg::LIMIT_W;
    localparam int SW = pfra_pkg::STATUS_W;
    localparam int OW = pfra_pkg::OUT_CNT_W;
    localparam logic [LW-1:0] LIMIT_CAP = LW'(pfra_pkg::DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(pfra_pkg::DEPTH - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [FW-1:0] first_reg;
    logic [LW-1:0] limit_reg;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic [FW-1:0] scan_reg, scan_next;
    logic          issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic [FW-1:0] pend_addr_reg, pend_addr_next;
    logic [SW-1:0] res_st_reg, res_st_next;
    logic [FW-1:0] res_frame_reg, res_frame_next;
    logic [OW-1:0] res_cnt_reg, res_cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [23:0]   out_data_reg, out_data_next;

    pfra_pkg::count_t mem [pfra_pkg::DEPTH];
    pfra_pkg::count_t rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             we;
    logic [AW-1:0]    wa;
    pfra_pkg::count_t wd;

    logic [LW-1:0] eff_lim;
    logic [1:0]    cmd_in;
    logic [FW-1:0] frame_in;
    logic          in_range;
    logic          in_reserved;
    logic          ev_reserved;
    logic          s_acc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign eff_lim     = (limit_reg < LIMIT_CAP) ? limit_reg : LIMIT_CAP;
    assign cmd_in      = s_tdata[1:0];
    assign frame_in    = s_tdata[13:2];
    assign in_range    = {1'b0, frame_in} < eff_lim;
    assign in_reserved = (cmd_in == pfra_pkg::CMD_FREE) && (frame_in < first_reg);
    assign ev_reserved = (cmd_reg == pfra_pkg::CMD_FREE) && (frame_reg < first_reg);
    assign rd_addr     = (state_reg == S_IDLE) ? frame_in[AW-1:0] : scan_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= '0;
            limit_reg <= LW'(pfra_pkg::INDEX_SPAN);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                pfra_pkg::REG_FIRST_ALLOC: first_reg <= cfg_data[FW-1:0];
                pfra_pkg::REG_FRAME_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        frame_next     = frame_reg;
        scan_next      = scan_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        res_st_next    = res_st_reg;
        res_frame_next = res_frame_reg;
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        we             = 1'b0;
        wa             = clr_reg;
        wd             = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    cmd_next   = cmd_in;
                    frame_next = frame_in;
                    if (cmd_in == pfra_pkg::CMD_ALLOC) begin
                        if (eff_lim <= {1'b0, first_reg}) begin
                            res_st_next    = pfra_pkg::ST_NO_FREE;
                            res_frame_next = '0;
                            res_cnt_next   = '0;
                            state_next     = S_OUT;
                        end else begin
                            scan_next  = FW'(eff_lim - 1'b1);
                            issue_next = 1'b1;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                    end else if (!in_range) begin
                        res_st_next    = in_reserved ? pfra_pkg::ST_RESERVED
                                                     : pfra_pkg::ST_RANGE;
                        res_frame_next = frame_in;
                        res_cnt_next   = '0;
                        state_next     = S_OUT;
                    end else begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                res_frame_next = frame_reg;
                wa             = frame_reg[AW-1:0];
                state_next     = S_OUT;
                if (ev_reserved) begin
                    res_st_next  = pfra_pkg::ST_RESERVED;
                    res_cnt_next = pfra_pkg::cnt_to_out(rd_data_reg);
                end else begin
                    case (cmd_reg)
                        pfra_pkg::CMD_FREE: begin
                            if (rd_data_reg == '0) begin
                                res_st_next  = pfra_pkg::ST_ALREADY_FREE;
                                res_cnt_next = '0;
                            end else begin
                                we           = 1'b1;
                                wd           = rd_data_reg - 1'b1;
                                res_st_next  = pfra_pkg::ST_OK;
                                res_cnt_next = pfra_pkg::cnt_to_out(wd);
                            end
                        end
                        pfra_pkg::CMD_SHARE: begin
                            if (rd_data_reg == '1) begin
                                res_st_next  = pfra_pkg::ST_SATURATED;
                                res_cnt_next = pfra_pkg::cnt_to_out(rd_data_reg);
                            end else begin
                                we           = 1'b1;
                                wd           = rd_data_reg + 1'b1;
                                res_st_next  = pfra_pkg::ST_OK;
                                res_cnt_next = pfra_pkg::cnt_to_out(wd);
                            end
                        end
                        default: begin
                            res_st_next  = pfra_pkg::ST_OK;
                            res_cnt_next = pfra_pkg::cnt_to_out(rd_data_reg);
                        end
                    endcase
                end
            end
            S_SCAN: begin
                pend_next      = issue_reg;
                pend_addr_next = scan_reg;
                issue_next     = issue_reg && (scan_reg != first_reg);
                scan_next      = scan_reg - 1'b1;
                if (pend_reg && (rd_data_reg == '0)) begin
                    we             = 1'b1;
                    wa             = pend_addr_reg[AW-1:0];
                    wd             = pfra_pkg::count_t'(1);
                    res_st_next    = pfra_pkg::ST_OK;
                    res_frame_next = pend_addr_reg;
                    res_cnt_next   = pfra_pkg::cnt_to_out(wd);
                    issue_next     = 1'b0;
                    pend_next      = 1'b0;
                    state_next     = S_OUT;
                end else if (!issue_reg) begin
                    res_st_next    = pfra_pkg::ST_NO_FREE;
                    res_frame_next = '0;
                    res_cnt_next   = '0;
                    pend_next      = 1'b0;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, res_cnt_reg, res_frame_reg, res_st_reg};
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        frame_reg     <= frame_next;
        scan_reg      <= scan_next;
        pend_addr_reg <= pend_addr_next;
        res_st_reg    <= res_st_next;
        res_frame_reg <= res_frame_next;
        res_cnt_reg   <= res_cnt_next;
        out_data_reg  <= out_data_next;
    end

`ifndef SYNTHESIS
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !s_tready)
        else $error("input accepted during clearing pass");

    a_accept_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("block ready again right after accept");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && (state_reg != S_CLR)) |-> ({{(LW-AW){1'b0}}, wa} < eff_lim))
        else $error("count write beyond the frame limit");

    a_alloc_count_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SCAN) && (state_next == S_OUT) &&
         (res_st_next == pfra_pkg::ST_OK)) |-> (wd == pfra_pkg::count_t'(1)))
        else $error("allocated frame count is not one");
`endif

endmodule

[bench/page_frame_refcount_allocator_top_tb.sv]
// self-checking testbench for the page frame refcount allocator top level
module page_frame_refcount_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfra_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [FRAME_W-1:0]   frame;
        logic [OUT_CNT_W-1:0] count;
    } frame_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_addr;
    logic [12:0] cfg_data;

    logic [COUNT_BITS-1:0] frame_refs [DEPTH];
    logic [FRAME_W-1:0]    first_alloc_q;
    logic [LIMIT_W-1:0]    frame_limit_q;
    frame_result_t         expected_results [$];
    logic [FRAME_W-1:0]    held_frames [$];
    frame_result_t         want_result;

    int error_count = 0;
    int idle_cycles = 0;
    int hold_req = 0;
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;

    always #1 aclk = ~aclk;

    page_frame_refcount_allocator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    function automatic int usable_frames();
        return (int'(frame_limit_q) > DEPTH) ? DEPTH : int'(frame_limit_q);
    endfunction

    function automatic frame_result_t apply_command(input logic [1:0] cmd,
                                                    input logic [FRAME_W-1:0] idx);
        frame_result_t r;
        int lim;
        int i;
        bit found;
        lim = usable_frames();
        r.status = ST_OK;
        r.frame = idx;
        r.count = '0;
        if (cmd == CMD_ALLOC) begin
            r.status = ST_NO_FREE;
            r.frame = '0;
            found = 1'b0;
            for (i = lim - 1; i >= int'(first_alloc_q) && !found; i--) begin
                if (frame_refs[i] == '0) begin
                    frame_refs[i] = COUNT_BITS'(1);
                    r.status = ST_OK;
                    r.frame = FRAME_W'(i);
                    r.count = OUT_CNT_W'(1);
                    found = 1'b1;
                end
            end
        end else if (cmd == CMD_FREE && idx < first_alloc_q) begin
            r.status = ST_RESERVED;
            r.count = (int'(idx) < lim) ? frame_refs[idx] : '0;
        end else if (int'(idx) >= lim) begin
            r.status = ST_RANGE;
        end else begin
            r.count = frame_refs[idx];
            case (cmd)
                CMD_FREE: begin
                    if (r.count == '0) begin
                        r.status = ST_ALREADY_FREE;
                    end else begin
                        r.count = r.count - 1'b1;
                        frame_refs[idx] = r.count;
                    end
                end
                CMD_SHARE: begin
                    if (r.count == '1) begin
                        r.status = ST_SATURATED;
                    end else begin
                        r.count = r.count + 1'b1;
                        frame_refs[idx] = r.count;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic logic [FRAME_W-1:0] pick_frame();
        int lim;
        int roll;
        lim = usable_frames();
        roll = $urandom_range(0, 19);
        if (roll < 12 && held_frames.size() > 0)
            return held_frames[$urandom_range(0, held_frames.size() - 1)];
        if (roll < 16 && lim > 0)
            return FRAME_W'($urandom_range(0, lim - 1));
        if (roll == 16)
            return FRAME_W'(lim);
        if (roll == 17)
            return first_alloc_q - 1'b1;
        return FRAME_W'($urandom_range(0, INDEX_SPAN - 1));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic [FRAME_W-1:0] idx);
        int gap;
        frame_result_t r;
        gap = tx_eager ? 0 : $urandom_range(0, 6);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, idx, cmd};
        do @(posedge aclk); while (!s_tready);
        r = apply_command(cmd, idx);
        expected_results.push_back(r);
        if (cmd == CMD_ALLOC && r.status == ST_OK) begin
            held_frames.push_back(r.frame);
            if (held_frames.size() > 64)
                void'(held_frames.pop_front());
        end
    endtask

    task automatic write_reg(input logic addr, input logic [LIMIT_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (addr == REG_FIRST_ALLOC)
            first_alloc_q = value[FRAME_W-1:0];
        else
            frame_limit_q = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_word(CMD_QUERY, 12'd0);
        send_word(CMD_QUERY, 12'hfff);
        send_word(CMD_ALLOC, 12'd0);
        send_word(CMD_ALLOC, 12'hfff);
        send_word(CMD_SHARE, 12'hfff);
        send_word(CMD_FREE, 12'hfff);
        send_word(CMD_FREE, 12'hfff);
        send_word(CMD_FREE, 12'hfff);
        send_word(CMD_SHARE, 12'd0);
        wait_idle();
        write_reg(REG_FIRST_ALLOC, 13'd4095);
        send_word(CMD_ALLOC, 12'd0);
        send_word(CMD_ALLOC, 12'd0);
        send_word(CMD_FREE, 12'd4094);
        send_word(CMD_QUERY, 12'd4094);
        wait_idle();
        // boundary above the limit: nothing to allocate
        write_reg(REG_FIRST_ALLOC, 13'd100);
        write_reg(REG_FRAME_LIMIT, 13'd50);
        send_word(CMD_ALLOC, 12'd0);
        send_word(CMD_FREE, 12'd70);
        send_word(CMD_FREE, 12'd0);
        send_word(CMD_SHARE, 12'd70);
        send_word(CMD_SHARE, 12'd10);
        send_word(CMD_QUERY, 12'd10);
        wait_idle();
        write_reg(REG_FRAME_LIMIT, 13'd0);
        send_word(CMD_QUERY, 12'd0);
        send_word(CMD_ALLOC, 12'd0);
        wait_idle();
        write_reg(REG_FIRST_ALLOC, 13'd0);
        write_reg(REG_FRAME_LIMIT, 13'd1);
        send_word(CMD_ALLOC, 12'd0);
        send_word(CMD_FREE, 12'd0);
        send_word(CMD_ALLOC, 12'd0);
        wait_idle();
        write_reg(REG_FRAME_LIMIT, 13'h1fff);
        send_word(CMD_QUERY, 12'hfff);
        send_word(CMD_FREE, 12'hffe);
        wait_idle();
    endtask

    task automatic test_count_saturation();
        int i;
        write_reg(REG_FIRST_ALLOC, 13'd0);
        write_reg(REG_FRAME_LIMIT, 13'd16);
        tx_eager = 1'b1;
        for (i = 0; i < 257; i++)
            send_word(CMD_SHARE, 12'd9);
        send_word(CMD_QUERY, 12'd9);
        tx_eager = 1'b0;
        for (i = 0; i < 4; i++)
            send_word(CMD_FREE, 12'd9);
        send_word(CMD_ALLOC, 12'd0);
        wait_idle();
    endtask

    task automatic random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            send_word(2'($urandom_range(0, 3)), FRAME_W'($urandom_range(0, INDEX_SPAN - 1)));
        else if (roll < 40)
            send_word(CMD_ALLOC, FRAME_W'($urandom_range(0, INDEX_SPAN - 1)));
        else if (roll < 65)
            send_word(CMD_FREE, pick_frame());
        else if (roll < 85)
            send_word(CMD_SHARE, pick_frame());
        else
            send_word(CMD_QUERY, pick_frame());
    endtask

    task automatic test_backpressure();
        int i;
        write_reg(REG_FIRST_ALLOC, 13'd2);
        write_reg(REG_FRAME_LIMIT, 13'd24);
        hold_req = 400;
        tx_eager = 1'b1;
        for (i = 0; i < 24; i++)
            random_word();
        tx_eager = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int phase;
        int i;
        int first;
        int lim;
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin first = 0; lim = 16; end
                1: begin first = 4095; lim = 4096; end
                2: begin first = 0; lim = 8191; end
                3: begin first = 20; lim = 12; end
                default: begin
                    first = $urandom_range(0, 48);
                    lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                       : first + $urandom_range(1, 48);
                end
            endcase
            write_reg(REG_FIRST_ALLOC, LIMIT_W'(first));
            write_reg(REG_FRAME_LIMIT, LIMIT_W'(lim));
            for (i = 0; i < 160; i++) begin
                if (i % 40 == 0) begin
                    tx_eager = ($urandom_range(0, 2) == 0);
                    rx_eager = ($urandom_range(0, 2) == 0);
                end
                random_word();
            end
            wait_idle();
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // result sink with random stalls and an occasional long hold-off
    initial begin
        int pause;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            pause = rx_eager ? 0 : $urandom_range(0, 6);
            if (hold_req > 0) begin
                pause = hold_req;
                hold_req = 0;
            end
            if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("word with nothing expected, tdata", m_tdata, 0);
            end else begin
                want_result = expected_results.pop_front();
                if (m_tdata[2:0] !== want_result.status)
                    report_mismatch("status", m_tdata[2:0], want_result.status);
                if (m_tdata[14:3] !== want_result.frame)
                    report_mismatch("result_frame", m_tdata[14:3], want_result.frame);
                if (m_tdata[22:15] !== want_result.count)
                    report_mismatch("ref_count", m_tdata[22:15], want_result.count);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("page_frame_refcount_allocator_top_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_addr = 1'b0;
        cfg_data = '0;
        foreach (frame_refs[i])
            frame_refs[i] = '0;
        first_alloc_q = '0;
        frame_limit_q = LIMIT_W'(4096);
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_count_saturation();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (64) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("words never delivered", 0, expected_results.size());
        if (error_count == 0)
            $display("page_frame_refcount_allocator_top_tb OK");
        else
            $display("page_frame_refcount_allocator_top_tb NOT OK");
        $finish;
    end

endmodule
